@@ design/stst_pkg.sv @@
// ----------------------------------------------------------------------------
// stst_pkg - sorted time slot table package
// Table sizing, entry layout, command and status codes.
// ----------------------------------------------------------------------------
package stst_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int DESC_BITS   = 16;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 14;
  localparam int ENT_W = KEY_W + DESC_BITS;

  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [DESC_BITS-1:0] desc_t;
  typedef logic [ENT_W-1:0]     entry_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [2:0]           status_t;
  typedef logic [1:0]           mode_t;

  localparam mode_t MODE_ADD  = 2'd0;
  localparam mode_t MODE_DEL  = 2'd1;
  localparam mode_t MODE_LIST = 2'd2;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_MONTH = 3'd1;
  localparam status_t ST_BAD_DAY   = 3'd2;
  localparam status_t ST_BAD_HOUR  = 3'd3;
  localparam status_t ST_TAKEN     = 3'd4;
  localparam status_t ST_NOT_FOUND = 3'd5;
  localparam status_t ST_FULL      = 3'd6;
  localparam status_t ST_LISTED    = 3'd7;

  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] HOUR_MAX  = 5'd23;

endpackage

@@ design/sorted_time_slot_table.sv @@
// ----------------------------------------------------------------------------
// sorted_time_slot_table - sorted table of (month, day, hour) time slots
// Add, delete and list over a key-ordered table kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. in_mode selects
//   add, delete or list; the key fields and in_desc_handle travel with it.
//   Results appear on the out_ ports for one cycle each, flagged by
//   out_valid; out_last marks the final result of a command. The receiver
//   cannot stall, so every result must be captured when it is shown.
// Timing:
//   One RAM pass, one entry per cycle, walks the table through a single
//   key comparator. A range error or an unused mode skips the scan and is
//   answered from S_FIN. Add scans up to the first larger key, then
//   carries each later entry one slot up; delete scans up, closing the gap;
//   list reads each entry in order.
//   A scan can stop before the end of the table; busy stays high until the
//   final result.
// Reset:
//   Synchronous reset empties the table; RAM contents need no clearing since
//   only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_time_slot_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  stst_pkg::mode_t   in_mode,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_day,
  input  logic [4:0]        in_hour,
  input  logic [15:0]       in_desc_handle,
  output logic              out_valid,
  output stst_pkg::status_t out_status,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [15:0]       out_desc,
  output logic              out_last
);

  import stst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  mode_t      mode_r, mode_nxt;
  key_t       key_r, key_nxt;
  entry_t     carry_r, carry_nxt;
  idx_t       addr_r, addr_nxt;
  cnt_t       rem_r, rem_nxt;
  logic       pend_r, pend_nxt;
  idx_t       pidx_r, pidx_nxt;
  logic       plast_r, plast_nxt;
  logic       found_r, found_nxt;
  status_t    st_r, st_nxt;
  idx_t       pos_r, pos_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [4:0]  out_hour_r, out_hour_nxt;
  logic [15:0] out_desc_r, out_desc_nxt;
  logic        out_last_r, out_last_nxt;

  logic    wr_en, rd_en;
  idx_t    wr_addr, rd_addr;
  entry_t  wr_data, rd_data;
  key_t    rd_key;
  desc_t   rd_desc;
  status_t range_st;
  logic    full;
  logic    stop;

  stst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key  = rd_data[ENT_W-1 -: KEY_W];
  assign rd_desc = rd_data[DESC_BITS-1:0];
  assign full    = (cnt_r == CNT_W'(MAX_ENTRIES));

  always_comb begin
    if (in_month == 4'd0 || in_month > MONTH_MAX) begin
      range_st = ST_BAD_MONTH;
    end else if (in_day == 5'd0) begin
      range_st = ST_BAD_DAY;
    end else if (in_hour > HOUR_MAX) begin
      range_st = ST_BAD_HOUR;
    end else begin
      range_st = ST_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    carry_nxt = carry_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    plast_nxt = plast_r;
    found_nxt = found_r;
    st_nxt    = st_r;
    pos_nxt   = pos_r;

    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_hour_nxt   = out_hour_r;
    out_desc_nxt   = out_desc_r;
    out_last_nxt   = out_last_r;

    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = addr_r;
    stop    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          key_nxt   = {in_month, in_day, in_hour};
          carry_nxt = {in_month, in_day, in_hour, desc_t'(in_desc_handle)};
          found_nxt = 1'b0;
          rem_nxt   = cnt_r;
          st_nxt    = ST_OK;
          pos_nxt   = '0;
          state_nxt = S_FIN;
          case (in_mode)
            MODE_ADD: begin
              if (range_st != ST_OK) begin
                st_nxt = range_st;
              end else if (cnt_r != '0) begin
                addr_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_DEL: begin
              if (range_st != ST_OK) begin
                st_nxt = range_st;
              end else if (cnt_r == '0) begin
                st_nxt = ST_NOT_FOUND;
              end else begin
                addr_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_LIST: begin
              if (cnt_r != '0) begin
                addr_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (pend_r) begin
          case (mode_r)
            MODE_ADD: begin
              // scanning upward: nothing moves until the key is known absent,
              // then the carried entry drops in and the read one moves on
              if (!found_r && rd_key == key_r) begin
                stop   = 1'b1;
                st_nxt = ST_TAKEN;
              end else if (found_r || rd_key > key_r) begin
                if (full) begin
                  stop   = 1'b1;
                  st_nxt = ST_FULL;
                end else begin
                  wr_en     = 1'b1;
                  wr_addr   = pidx_r;
                  wr_data   = carry_r;
                  carry_nxt = rd_data;
                  found_nxt = 1'b1;
                  if (plast_r) begin
                    stop    = 1'b1;
                    st_nxt  = ST_OK;
                    pos_nxt = pidx_r + IDX_W'(1);
                  end
                end
              end else if (plast_r) begin
                stop    = 1'b1;
                st_nxt  = full ? ST_FULL : ST_OK;
                pos_nxt = pidx_r + IDX_W'(1);
              end
            end
            MODE_DEL: begin
              // after the match, every later entry moves down one slot
              if (found_r) begin
                wr_en   = 1'b1;
                wr_addr = pidx_r - IDX_W'(1);
                wr_data = rd_data;
                if (plast_r) begin
                  stop   = 1'b1;
                  st_nxt = ST_OK;
                end
              end else if (rd_key == key_r) begin
                found_nxt = 1'b1;
                if (plast_r) begin
                  stop   = 1'b1;
                  st_nxt = ST_OK;
                end
              end else if (rd_key > key_r || plast_r) begin
                stop   = 1'b1;
                st_nxt = ST_NOT_FOUND;
              end
            end
            MODE_LIST: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_LISTED;
              out_month_nxt  = rd_key[13:10];
              out_day_nxt    = rd_key[9:5];
              out_hour_nxt   = rd_key[4:0];
              out_desc_nxt   = 16'(rd_desc);
              out_last_nxt   = 1'b0;
              if (plast_r) begin
                stop   = 1'b1;
                st_nxt = ST_OK;
              end
            end
            default: begin
              stop = 1'b1;
            end
          endcase
        end

        if (stop) begin
          state_nxt = S_FIN;
        end else if (rem_r != '0) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          pidx_nxt  = addr_r;
          plast_nxt = (rem_r == CNT_W'(1));
          rem_nxt   = rem_r - CNT_W'(1);
          addr_nxt  = addr_r + IDX_W'(1);
        end
      end

      S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = st_r;
        out_month_nxt  = '0;
        out_day_nxt    = '0;
        out_hour_nxt   = '0;
        out_desc_nxt   = '0;
        out_last_nxt   = 1'b1;
        if (st_r == ST_OK && mode_r == MODE_ADD) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = carry_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (st_r == ST_OK && mode_r == MODE_DEL) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    carry_r      <= carry_nxt;
    addr_r       <= addr_nxt;
    rem_r        <= rem_nxt;
    pidx_r       <= pidx_nxt;
    plast_r      <= plast_nxt;
    st_r         <= st_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_hour_r   <= out_hour_nxt;
    out_desc_r   <= out_desc_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_hour   = out_hour_r;
  assign out_desc   = out_desc_r;
  assign out_last   = out_last_r;

endmodule

@@ design/stst_ram.sv @@
// ----------------------------------------------------------------------------
// stst_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/stst_chk.sv @@
// ----------------------------------------------------------------------------
// stst_chk - port-level checker for the sorted time slot table
// Watches command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module stst_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input stst_pkg::status_t out_status,
  input logic [3:0]        out_month,
  input logic [4:0]        out_day,
  input logic [4:0]        out_hour,
  input logic [15:0]       out_desc,
  input logic              out_last
);

  import stst_pkg::*;

  // an accepted transaction always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // the final result releases the block in the same cycle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy still high on final result");

  // non-final results come only from a list that is still running
  a_mid_listed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && out_status == ST_LISTED)
    else $error("non-final result outside a list");

  // non-listing results carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_LISTED |->
      out_month == '0 && out_day == '0 && out_hour == '0 && out_desc == '0)
    else $error("status result with nonzero payload");

  // every non-final result is followed directly by another result, no gap within a list
  a_list_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside list output");

endmodule

bind sorted_time_slot_table stst_chk u_stst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status),
  .out_month  (out_month),
  .out_day    (out_day),
  .out_hour   (out_hour),
  .out_desc   (out_desc),
  .out_last   (out_last)
);
